@@ sv/trq_pkg.sv @@
// constants and codes shared by the task run queue
package trq_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int LINK_W    = $clog2(NUM_SLOTS + 1);
  localparam int ID_W      = 32;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NUM_SLOTS);

  // operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_FIND = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_MISUSE = 2'd2;

endpackage

@@ sv/task_run_queue_core.sv @@
// task run queue: doubly linked fifo of task slots held in link memories
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | func, task_slot, task_id
//  out     | out_valid / out_stall| slot_out, status, empty_flag, queued_count
//
// enqueue passes decode, the tail link update and the result state; dequeue
// and remove pass decode, the unlink and the result state; a rejected operation
// or a dequeue on an empty queue goes to the result state; find reads and
// compares entries to a match or the list end; memory reads are registered.
// reset is synchronous; it empties the queue and clears the membership flags.
// one transaction is worked on at a time; a waiting result blocks only the
// final load, and the next input is taken as soon as the result is registered.
module task_run_queue_core
  import trq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [SLOT_W-1:0] task_slot,
  input  logic [ID_W-1:0]   task_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot_out,
  output logic [1:0]        status,
  output logic              empty_flag,
  output logic [LINK_W-1:0] queued_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_ENQ2   = 3'd2;
  localparam logic [2:0] S_UNLINK = 3'd3;
  localparam logic [2:0] S_FRD    = 3'd4;
  localparam logic [2:0] S_FCMP   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]          state, state_next;
  logic [LINK_W-1:0]   head, head_next;
  logic [LINK_W-1:0]   tail, tail_next;
  logic [LINK_W-1:0]   count, count_next;
  logic [NUM_SLOTS-1:0] member, member_next;

  logic [1:0]          op;
  logic [SLOT_W-1:0]   slot;
  logic [ID_W-1:0]     id;
  logic [LINK_W-1:0]   cur, cur_next;
  logic [LINK_W-1:0]   steps, steps_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic [1:0]          res_status, res_status_next;

  // memories
  logic [LINK_W-1:0] next_mem [NUM_SLOTS];
  logic [LINK_W-1:0] prev_mem [NUM_SLOTS];
  logic [ID_W-1:0]   id_mem   [NUM_SLOTS];

  logic [SLOT_W-1:0] rd_addr;
  logic [LINK_W-1:0] next_rd, prev_rd;
  logic [ID_W-1:0]   id_rd;

  logic              next_we, prev_we, id_we;
  logic [SLOT_W-1:0] next_waddr, prev_waddr;
  logic [LINK_W-1:0] next_wdata, prev_wdata;

  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (id_we) begin
      id_mem[slot] <= id;
    end
    next_rd <= next_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
    id_rd   <= id_mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    member_next     = member;
    cur_next        = cur;
    steps_next      = steps;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    rd_addr         = slot;
    next_we         = 1'b0;
    prev_we         = 1'b0;
    id_we           = 1'b0;
    next_waddr      = slot;
    prev_waddr      = slot;
    next_wdata      = NONE_LINK;
    prev_wdata      = tail;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        res_slot_next   = '0;
        res_status_next = ST_OK;
        case (op)
          OP_ENQ: begin
            if (member[slot]) begin
              res_status_next = ST_MISUSE;
              state_next      = S_OUT;
            end else begin
              // new tail entry: id, back link to old tail, no forward link
              id_we      = 1'b1;
              prev_we    = 1'b1;
              next_we    = 1'b1;
              state_next = S_ENQ2;
            end
          end
          OP_DEQ: begin
            if (head == NONE_LINK) begin
              res_status_next = ST_EMPTY;
              state_next      = S_OUT;
            end else begin
              rd_addr       = head[SLOT_W-1:0];
              cur_next      = head;
              res_slot_next = head[SLOT_W-1:0];
              state_next    = S_UNLINK;
            end
          end
          OP_REM: begin
            if (!member[slot]) begin
              res_status_next = ST_MISUSE;
              state_next      = S_OUT;
            end else begin
              cur_next   = {1'b0, slot};
              state_next = S_UNLINK;
            end
          end
          default: begin
            cur_next   = head;
            steps_next = '0;
            state_next = S_FRD;
          end
        endcase
      end
      S_ENQ2: begin
        if (tail != NONE_LINK) begin
          next_we    = 1'b1;
          next_waddr = tail[SLOT_W-1:0];
          next_wdata = {1'b0, slot};
        end
        if (head == NONE_LINK) begin
          head_next = {1'b0, slot};
        end
        tail_next          = {1'b0, slot};
        member_next[slot]  = 1'b1;
        count_next         = count + 1'b1;
        state_next         = S_OUT;
      end
      S_UNLINK: begin
        // prev_rd / next_rd hold the links of the entry being taken out
        if (prev_rd != NONE_LINK) begin
          next_we    = 1'b1;
          next_waddr = prev_rd[SLOT_W-1:0];
          next_wdata = next_rd;
        end else begin
          head_next = next_rd;
        end
        if (next_rd != NONE_LINK) begin
          prev_we    = 1'b1;
          prev_waddr = next_rd[SLOT_W-1:0];
          prev_wdata = prev_rd;
        end else begin
          tail_next = prev_rd;
        end
        member_next[cur[SLOT_W-1:0]] = 1'b0;
        if (count != '0) begin
          count_next = count - 1'b1;
        end
        state_next = S_OUT;
      end
      S_FRD: begin
        if (cur == NONE_LINK || steps == LINK_W'(NUM_SLOTS)) begin
          res_status_next = ST_EMPTY;
          state_next      = S_OUT;
        end else begin
          rd_addr    = cur[SLOT_W-1:0];
          state_next = S_FCMP;
        end
      end
      S_FCMP: begin
        if (id_rd == id) begin
          res_slot_next = cur[SLOT_W-1:0];
          state_next    = S_OUT;
        end else begin
          cur_next   = next_rd;
          steps_next = steps + 1'b1;
          state_next = S_FRD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NONE_LINK;
      tail      <= NONE_LINK;
      count     <= '0;
      member    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      member <= member_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op   <= func;
      slot <= task_slot;
      id   <= task_id;
    end
    cur        <= cur_next;
    steps      <= steps_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    if (state == S_OUT && out_free) begin
      slot_out     <= res_slot;
      status       <= res_status;
      empty_flag   <= (count == '0);
      queued_count <= count;
    end
  end

endmodule

@@ bench/task_run_queue_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the task run queue core: random and directed queue operations
module task_run_queue_core_tb;
  import trq_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_PRINTED   = 40;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } queue_op_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
    logic              empty;
    logic [LINK_W-1:0] count;
  } queue_res_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        func = OP_ENQ;
  logic [SLOT_W-1:0] task_slot = '0;
  logic [ID_W-1:0]   task_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] slot_out;
  logic [1:0]        status;
  logic              empty_flag;
  logic [LINK_W-1:0] queued_count;

  task_run_queue_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .task_slot    (task_slot),
    .task_id      (task_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_out     (slot_out),
    .status       (status),
    .empty_flag   (empty_flag),
    .queued_count (queued_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // queue state as the block should hold it
  logic [LINK_W-1:0] q_head, q_tail, q_count;
  logic [LINK_W-1:0] q_next [NUM_SLOTS];
  logic [LINK_W-1:0] q_prev [NUM_SLOTS];
  logic [ID_W-1:0]   q_id   [NUM_SLOTS];
  bit                q_member [NUM_SLOTS];

  // membership as seen when the stimulus is generated
  int                gen_order [$];
  bit                gen_member [NUM_SLOTS];
  logic [ID_W-1:0]   gen_id [NUM_SLOTS];

  queue_op_t  pending_ops [$];
  queue_res_t want_results [$];

  int n_errors = 0;
  int n_results = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  task automatic clear_queue_state();
    q_head  = NONE_LINK;
    q_tail  = NONE_LINK;
    q_count = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      q_member[k] = 1'b0;
    end
  endtask

  task automatic unlink_entry(input logic [SLOT_W-1:0] s);
    logic [LINK_W-1:0] p, n;
    p = q_prev[s];
    n = q_next[s];
    if (p < NUM_SLOTS) q_next[p[SLOT_W-1:0]] = n;
    else q_head = n;
    if (n < NUM_SLOTS) q_prev[n[SLOT_W-1:0]] = p;
    else q_tail = p;
    q_prev[s]   = NONE_LINK;
    q_next[s]   = NONE_LINK;
    q_member[s] = 1'b0;
    if (q_count > 0) q_count--;
  endtask

  task automatic predict_queue_op(input queue_op_t op, output queue_res_t res);
    logic [LINK_W-1:0] walk;
    int steps;
    bit hit;
    res = '0;
    res.status = ST_OK;
    case (op.func)
      OP_ENQ: begin
        if (q_member[op.slot]) begin
          res.status = ST_MISUSE;
        end else begin
          q_id[op.slot]   = op.id;
          q_prev[op.slot] = q_tail;
          q_next[op.slot] = NONE_LINK;
          if (q_tail < NUM_SLOTS) q_next[q_tail[SLOT_W-1:0]] = LINK_W'(op.slot);
          q_tail = LINK_W'(op.slot);
          if (q_head >= NUM_SLOTS) q_head = LINK_W'(op.slot);
          q_member[op.slot] = 1'b1;
          q_count++;
        end
      end
      OP_DEQ: begin
        if (q_head >= NUM_SLOTS) begin
          res.status = ST_EMPTY;
        end else begin
          res.slot = q_head[SLOT_W-1:0];
          unlink_entry(q_head[SLOT_W-1:0]);
        end
      end
      OP_REM: begin
        if (!q_member[op.slot]) res.status = ST_MISUSE;
        else unlink_entry(op.slot);
      end
      default: begin
        res.status = ST_EMPTY;
        walk = q_head;
        steps = 0;
        hit = 1'b0;
        while (!hit && walk < NUM_SLOTS && steps < NUM_SLOTS) begin
          if (q_id[walk[SLOT_W-1:0]] == op.id) begin
            res.slot = walk[SLOT_W-1:0];
            res.status = ST_OK;
            hit = 1'b1;
          end else begin
            walk = q_next[walk[SLOT_W-1:0]];
            steps++;
          end
        end
      end
    endcase
    res.empty = (q_count == 0);
    res.count = q_count;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (n_errors < MAX_PRINTED)
      $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    else if (r == 5) return '0;
    else if (r == 6) return '1;
    else return $urandom_range(1, 6);  // small pool so ids repeat
  endfunction

  function automatic int pick_free_slot();
    int start, s;
    start = $urandom_range(0, NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = (start + k) % NUM_SLOTS;
      if (!gen_member[s]) return s;
    end
    return -1;
  endfunction

  task automatic add_op(input logic [1:0] f, input int slot, input logic [ID_W-1:0] id);
    queue_op_t op;
    int at;
    op.func = f;
    op.slot = slot[SLOT_W-1:0];
    op.id   = id;
    pending_ops.push_back(op);
    case (f)
      OP_ENQ: begin
        if (!gen_member[op.slot]) begin
          gen_member[op.slot] = 1'b1;
          gen_id[op.slot] = id;
          gen_order.push_back(op.slot);
        end
      end
      OP_DEQ: begin
        if (gen_order.size() > 0) begin
          gen_member[gen_order[0]] = 1'b0;
          void'(gen_order.pop_front());
        end
      end
      OP_REM: begin
        if (gen_member[op.slot]) begin
          gen_member[op.slot] = 1'b0;
          at = -1;
          for (int k = 0; k < gen_order.size(); k++) begin
            if (gen_order[k] == op.slot) at = k;
          end
          gen_order.delete(at);
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_random_op(input mix_t mix);
    int pick, s;
    logic [1:0] f;
    logic [ID_W-1:0] id;
    // a tenth of the traffic is unconstrained noise, misuse included
    if ($urandom_range(0, 9) == 0) begin
      add_op(2'($urandom_range(0, 3)), $urandom_range(0, NUM_SLOTS - 1), rand_id());
      return;
    end
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  f = (pick < 60) ? OP_ENQ : (pick < 72) ? OP_DEQ : (pick < 84) ? OP_REM : OP_FIND;
      MIX_DRAIN: f = (pick < 20) ? OP_ENQ : (pick < 50) ? OP_DEQ : (pick < 75) ? OP_REM : OP_FIND;
      default:   f = (pick < 35) ? OP_ENQ : (pick < 55) ? OP_DEQ : (pick < 72) ? OP_REM : OP_FIND;
    endcase
    case (f)
      OP_ENQ: begin
        s = pick_free_slot();
        if (s < 0) s = $urandom_range(0, NUM_SLOTS - 1);
        add_op(OP_ENQ, s, rand_id());
      end
      OP_DEQ: add_op(OP_DEQ, $urandom_range(0, NUM_SLOTS - 1), rand_id());
      OP_REM: begin
        if (gen_order.size() == 0) begin
          s = $urandom_range(0, NUM_SLOTS - 1);
        end else begin
          pick = $urandom_range(0, 2);
          if (pick == 0) s = gen_order[0];
          else if (pick == 1) s = gen_order[$];
          else s = gen_order[$urandom_range(0, gen_order.size() - 1)];
        end
        add_op(OP_REM, s, rand_id());
      end
      default: begin
        pick = $urandom_range(0, 99);
        if (gen_order.size() == 0 || pick < 25) id = rand_id();
        else if (pick < 40) id = gen_id[gen_order[$]];
        else id = gen_id[gen_order[$urandom_range(0, gen_order.size() - 1)]];
        add_op(OP_FIND, $urandom_range(0, NUM_SLOTS - 1), id);
      end
    endcase
  endtask

  // hold off the sender until every result is back
  task automatic drain_all();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || want_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    queue_op_t op;
    queue_res_t res;
    logic hold;
    if (rst) begin
      clear_queue_state();
      in_valid <= 1'b0;
    end else begin
      hold = in_valid;
      if (in_valid && !in_stall) begin
        op.func = func;
        op.slot = task_slot;
        op.id   = task_id;
        predict_queue_op(op, res);
        want_results.push_back(res);
        hold = 1'b0;
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          func      <= op.func;
          task_slot <= op.slot;
          task_id   <= op.id;
          hold = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= hold;
    end
  end

  always @(posedge clk) begin : monitor
    queue_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          report_mismatch("unexpected result, slot_out", slot_out, -1);
        end else begin
          want = want_results.pop_front();
          if (slot_out !== want.slot) report_mismatch("slot_out", slot_out, want.slot);
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (empty_flag !== want.empty) report_mismatch("empty_flag", empty_flag, want.empty);
          if (queued_count !== want.count) report_mismatch("queued_count", queued_count, want.count);
          n_results++;
        end
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(32, 256);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((cycle_count % 11) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int n_random, phase, phase_len, s;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      gen_member[k] = 1'b0;
    end

    add_op(OP_DEQ, 0, 32'h0000_0000);     // dequeue on an empty queue
    add_op(OP_FIND, 63, 32'hFFFF_FFFF);   // find on an empty queue
    add_op(OP_REM, 0, 32'h0000_0000);     // remove of a slot not queued
    add_op(OP_ENQ, 0, 32'h0000_0000);
    add_op(OP_ENQ, 0, 32'h1234_5678);     // enqueue of a slot already queued
    add_op(OP_ENQ, 63, 32'hFFFF_FFFF);
    add_op(OP_ENQ, 21, 32'h5555_5555);
    add_op(OP_ENQ, 42, 32'hAAAA_AAAA);
    add_op(OP_FIND, 0, 32'hAAAA_AAAA);    // match at the tail
    add_op(OP_FIND, 21, 32'h0000_0000);   // match on slot zero
    add_op(OP_FIND, 42, 32'h1234_5678);   // no match
    add_op(OP_REM, 63, 32'h0000_0000);    // unlink from the middle
    add_op(OP_REM, 63, 32'h0000_0000);    // no longer queued
    add_op(OP_ENQ, 63, 32'h0000_0000);    // duplicate id behind slot zero
    add_op(OP_REM, 0, 32'h0000_0000);     // unlink the head
    add_op(OP_FIND, 0, 32'h0000_0000);    // first match moves to slot 63
    add_op(OP_REM, 63, 32'h0000_0000);    // unlink the tail
    add_op(OP_DEQ, 0, 32'h0000_0000);
    add_op(OP_DEQ, 0, 32'h0000_0000);
    add_op(OP_DEQ, 0, 32'h0000_0000);     // empty again
    add_op(OP_ENQ, 7, 32'h8000_0001);
    add_op(OP_DEQ, 0, 32'h0000_0000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    drain_all();

    // fill every slot, then push on a full queue and walk the whole list
    s = pick_free_slot();
    while (s >= 0) begin
      add_op(OP_ENQ, s, rand_id());
      s = pick_free_slot();
    end
    add_op(OP_ENQ, $urandom_range(0, NUM_SLOTS - 1), $urandom);
    add_op(OP_FIND, $urandom_range(0, NUM_SLOTS - 1), gen_id[gen_order[NUM_SLOTS - 1]]);
    add_op(OP_FIND, $urandom_range(0, NUM_SLOTS - 1), $urandom);
    drain_all();

    n_random = 0;
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      phase_len = $urandom_range(100, 200);
      if (phase_len > RANDOM_ITEMS - n_random) phase_len = RANDOM_ITEMS - n_random;
      for (int k = 0; k < phase_len; k++) begin
        add_random_op(mix_t'(phase % 3));
      end
      n_random += phase_len;
      phase++;
      drain_all();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/trq_pkg.sv
sv/task_run_queue_core.sv
bench/task_run_queue_core_tb.sv
